// File: hw/rtl/ulcp_pkg.sv
package ulcp_pkg;

	localparam int LENGTH_LIMIT = 63;
	localparam int LEN_W = $clog2(LENGTH_LIMIT + 1);
	localparam int STORE_DEPTH = 12;
	localparam int IDX_W = $clog2(STORE_DEPTH);

	localparam int CMD_DEPTH = 2;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
	localparam int RES_DEPTH = 2;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);
	localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_ERASE = 8'd127;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_LED_LO = 8'h36;
	localparam logic [7:0] CH_LED_HI = 8'h38;
	localparam logic [7:0] CH_LED_BASE = 8'h35;

	localparam logic [7:0] WHEEL_THIRD = 8'd85;
	localparam logic [7:0] WHEEL_TWO_THIRDS = 8'd170;
	localparam logic [7:0] WHEEL_MAX = 8'd255;

	localparam logic [7:0] RAINBOW_TEXT [STORE_DEPTH] = '{
		8'h23, 8'h46, 8'h55, 8'h4C, 8'h4C, 8'h52,
		8'h41, 8'h49, 8'h4E, 8'h42, 8'h4F, 8'h57
	};

	typedef enum logic [1:0] {
		OP_CHAR  = 2'd0,
		OP_ERASE = 2'd1,
		OP_CR    = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} cmd_t;

	typedef enum logic [3:0] {
		KIND_NONE     = 4'd0,
		KIND_ECHO     = 4'd1,
		KIND_ERASE    = 4'd2,
		KIND_SET_ONE  = 4'd3,
		KIND_SET_ALL  = 4'd4,
		KIND_BAD_LEN  = 4'd5,
		KIND_BAD_HEX  = 4'd6,
		KIND_BAD_LED  = 4'd7,
		KIND_RAINBOW  = 4'd8
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] echo_byte;
		logic [1:0] led_select;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} res_t;

	function automatic logic hex_ok(input logic [7:0] c);
		return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h46));
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		if (c <= 8'h39) begin
			v = c - 8'h30;
		end else begin
			v = c - 8'h37;
		end
		return v[3:0];
	endfunction

endpackage

// File: hw/rtl/ulcp_front.sv
module ulcp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              func,
	input  logic [7:0]        rx_byte,
	output logic              cmd_valid,
	output ulcp_pkg::cmd_t    cmd,
	input  logic              cmd_take
);

	ulcp_pkg::cmd_t                     mem_q [ulcp_pkg::CMD_DEPTH];
	logic [ulcp_pkg::CMD_PTR_W-1:0]     wr_q;
	logic [ulcp_pkg::CMD_PTR_W-1:0]     rd_q;
	logic [ulcp_pkg::CMD_CNT_W-1:0]     cnt_q;
	logic                               wr_en;
	logic                               rd_en;
	ulcp_pkg::cmd_t                     cls;

	// classify the incoming word
	always_comb begin
		cls.data = rx_byte;
		priority if (func) begin
			cls.op = ulcp_pkg::OP_TICK;
		end else if (rx_byte == ulcp_pkg::CH_CR) begin
			cls.op = ulcp_pkg::OP_CR;
		end else if (rx_byte == ulcp_pkg::CH_ERASE) begin
			cls.op = ulcp_pkg::OP_ERASE;
		end else begin
			cls.op = ulcp_pkg::OP_CHAR;
		end
	end

	assign full = (cnt_q == ulcp_pkg::CMD_CNT_W'(ulcp_pkg::CMD_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd = mem_q[rd_q];
	assign wr_en = push && !full;
	assign rd_en = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= wr_q + 1'b1;
			end
			if (rd_en) begin
				rd_q <= rd_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/ulcp_back.sv
module ulcp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  ulcp_pkg::cmd_t    cmd,
	output logic              cmd_take,
	output logic              empty,
	input  logic              pop,
	output ulcp_pkg::res_t    res
);

	logic                               rainbow_q;
	logic [ulcp_pkg::LEN_W-1:0]         len_q;
	logic [7:0]                         chars_q [ulcp_pkg::STORE_DEPTH];
	logic                               tz_q;
	logic [7:0]                         wheel_q;

	ulcp_pkg::res_t                     res_mem_q [ulcp_pkg::RES_DEPTH];
	logic [ulcp_pkg::RES_PTR_W-1:0]     res_wr_q;
	logic [ulcp_pkg::RES_PTR_W-1:0]     res_rd_q;
	logic [ulcp_pkg::RES_CNT_W-1:0]     res_cnt_q;
	logic                               res_full;
	logic                               res_pop;

	logic [ulcp_pkg::STORE_DEPTH-1:0]   nz;
	logic [ulcp_pkg::STORE_DEPTH-1:0]   rb_eq;
	logic [5:0]                         hex_good;
	logic                               len8;
	logic                               len12;
	logic                               len_le12;
	logic                               len_lt12;
	logic                               len_eq12;
	logic                               len_room;
	logic [ulcp_pkg::LEN_W-1:0]         len_dec;
	logic [7:0]                         led_diff;
	logic [7:0]                         wp;
	logic [7:0]                         wq;
	logic [7:0]                         w3;
	ulcp_pkg::res_t                     res_d;

	assign res_full = (res_cnt_q == ulcp_pkg::RES_CNT_W'(ulcp_pkg::RES_DEPTH));
	assign empty = (res_cnt_q == '0);
	assign res_pop = pop && !empty;
	assign res = res_mem_q[res_rd_q];
	// a slot frees up this cycle if the oldest result is taken
	assign cmd_take = cmd_valid && (!res_full || res_pop);

	assign len_le12 = (len_q <= ulcp_pkg::LEN_W'(ulcp_pkg::STORE_DEPTH));
	assign len_lt12 = (len_q < ulcp_pkg::LEN_W'(ulcp_pkg::STORE_DEPTH));
	assign len_eq12 = (len_q == ulcp_pkg::LEN_W'(ulcp_pkg::STORE_DEPTH));
	assign len_room = (len_q < ulcp_pkg::LEN_W'(ulcp_pkg::LENGTH_LIMIT));
	assign len_dec = len_q - 1'b1;

	always_comb begin
		for (int i = 0; i < ulcp_pkg::STORE_DEPTH; i++) begin
			nz[i] = (chars_q[i] != 8'd0);
			rb_eq[i] = (chars_q[i] == ulcp_pkg::RAINBOW_TEXT[i]);
		end
		for (int i = 0; i < 6; i++) begin
			hex_good[i] = ulcp_pkg::hex_ok(chars_q[i + 1]);
		end
	end

	// chars past the line end are always zero, so the text length follows from
	// the first zero byte
	assign len8 = (&nz[7:0]) && !nz[8];
	assign len12 = (&nz) && (len_le12 || tz_q);
	assign led_diff = chars_q[7] - ulcp_pkg::CH_LED_BASE;

	// color wheel
	always_comb begin
		wp = ulcp_pkg::WHEEL_MAX - wheel_q;
		if (wp < ulcp_pkg::WHEEL_THIRD) begin
			wq = wp;
		end else if (wp < ulcp_pkg::WHEEL_TWO_THIRDS) begin
			wq = wp - ulcp_pkg::WHEEL_THIRD;
		end else begin
			wq = wp - ulcp_pkg::WHEEL_TWO_THIRDS;
		end
		w3 = wq + {wq[6:0], 1'b0};
	end

	always_comb begin
		res_d = '0;
		res_d.kind = ulcp_pkg::KIND_NONE;
		unique case (cmd.op)
			ulcp_pkg::OP_TICK: begin
				if (rainbow_q) begin
					res_d.kind = ulcp_pkg::KIND_SET_ALL;
					if (wp < ulcp_pkg::WHEEL_THIRD) begin
						res_d.red = ulcp_pkg::WHEEL_MAX - w3;
						res_d.green = w3;
					end else if (wp < ulcp_pkg::WHEEL_TWO_THIRDS) begin
						res_d.red = w3;
						res_d.blue = ulcp_pkg::WHEEL_MAX - w3;
					end else begin
						res_d.green = w3;
						res_d.blue = ulcp_pkg::WHEEL_MAX - w3;
					end
				end
			end
			ulcp_pkg::OP_CR: begin
				if (!rainbow_q) begin
					priority if (len12 && (&rb_eq)) begin
						res_d.kind = ulcp_pkg::KIND_RAINBOW;
					end else if (!len8 || (chars_q[0] != ulcp_pkg::CH_HASH)) begin
						res_d.kind = ulcp_pkg::KIND_BAD_LEN;
					end else if (!(&hex_good)) begin
						res_d.kind = ulcp_pkg::KIND_BAD_HEX;
					end else if ((chars_q[7] < ulcp_pkg::CH_LED_LO) ||
						(chars_q[7] > ulcp_pkg::CH_LED_HI)) begin
						res_d.kind = ulcp_pkg::KIND_BAD_LED;
					end else begin
						res_d.kind = ulcp_pkg::KIND_SET_ONE;
						res_d.led_select = led_diff[1:0];
						res_d.red = {ulcp_pkg::hex_val(chars_q[1]),
							ulcp_pkg::hex_val(chars_q[2])};
						res_d.green = {ulcp_pkg::hex_val(chars_q[3]),
							ulcp_pkg::hex_val(chars_q[4])};
						res_d.blue = {ulcp_pkg::hex_val(chars_q[5]),
							ulcp_pkg::hex_val(chars_q[6])};
					end
				end
			end
			ulcp_pkg::OP_ERASE: begin
				if (!rainbow_q && (len_q != '0)) begin
					res_d.kind = ulcp_pkg::KIND_ERASE;
				end
			end
			ulcp_pkg::OP_CHAR: begin
				if (!rainbow_q && len_room) begin
					res_d.kind = ulcp_pkg::KIND_ECHO;
					res_d.echo_byte = cmd.data;
				end
			end
			default: begin
				res_d.kind = ulcp_pkg::KIND_NONE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			res_mem_q[res_wr_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rainbow_q <= 1'b0;
			len_q <= '0;
			tz_q <= 1'b0;
			wheel_q <= '0;
			for (int i = 0; i < ulcp_pkg::STORE_DEPTH; i++) begin
				chars_q[i] <= '0;
			end
			res_wr_q <= '0;
			res_rd_q <= '0;
			res_cnt_q <= '0;
		end else begin
			if (cmd_take) begin
				res_wr_q <= res_wr_q + 1'b1;
				unique case (cmd.op)
					ulcp_pkg::OP_TICK: begin
						if (rainbow_q) begin
							wheel_q <= wheel_q + 1'b1;
						end
					end
					ulcp_pkg::OP_CR: begin
						if (!rainbow_q) begin
							if (len12 && (&rb_eq)) begin
								rainbow_q <= 1'b1;
							end
							len_q <= '0;
							tz_q <= 1'b0;
							for (int i = 0; i < ulcp_pkg::STORE_DEPTH; i++) begin
								chars_q[i] <= '0;
							end
						end
					end
					ulcp_pkg::OP_ERASE: begin
						if (!rainbow_q && (len_q != '0)) begin
							len_q <= len_dec;
							if (len_dec < ulcp_pkg::LEN_W'(ulcp_pkg::STORE_DEPTH)) begin
								chars_q[len_dec[ulcp_pkg::IDX_W-1:0]] <= '0;
							end else if (len_dec == ulcp_pkg::LEN_W'(ulcp_pkg::STORE_DEPTH)) begin
								tz_q <= 1'b0;
							end
						end
					end
					ulcp_pkg::OP_CHAR: begin
						if (!rainbow_q && len_room) begin
							len_q <= len_q + 1'b1;
							if (len_lt12) begin
								chars_q[len_q[ulcp_pkg::IDX_W-1:0]] <= cmd.data;
							end else if (len_eq12) begin
								tz_q <= (cmd.data == 8'd0);
							end
						end
					end
					default: begin
						len_q <= len_q;
					end
				endcase
			end
			if (res_pop) begin
				res_rd_q <= res_rd_q + 1'b1;
			end
			if (cmd_take && !res_pop) begin
				res_cnt_q <= res_cnt_q + 1'b1;
			end else if (res_pop && !cmd_take) begin
				res_cnt_q <= res_cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/uart_led_color_command_parser_top.sv
// Each pushed word is queued; when taken, its result is registered into the result queue.
// Throughput: one word per cycle unless a full queue stalls; both queues are two words deep.
// The result of each word is produced in the single cycle it is executed by the back end.
// Reset (arst_n low, asynchronous): both queues empty, line cleared, rainbow mode off,
// wheel position zero.
module uart_led_color_command_parser_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       func,
	input  logic [7:0] rx_byte,
	output logic       empty,
	input  logic       pop,
	output logic [3:0] kind,
	output logic [7:0] echo_byte,
	output logic [1:0] led_select,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue
);

	logic              cmd_valid;
	logic              cmd_take;
	ulcp_pkg::cmd_t    cmd;
	ulcp_pkg::res_t    res;

	ulcp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.func      (func),
		.rx_byte   (rx_byte),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	ulcp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	assign kind = res.kind;
	assign echo_byte = res.echo_byte;
	assign led_select = res.led_select;
	assign red = res.red;
	assign green = res.green;
	assign blue = res.blue;

endmodule
